// File: design/tmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_pkg: thruster mixing matrix shared definitions
// Field types, arithmetic constants, coefficient table, register codes.
// ----------------------------------------------------------------------------
package tmm_pkg;

  localparam int N_THR    = 8;
  localparam int N_CMD    = 6;
  localparam int CMD_W    = 16;
  localparam int SPEED_W  = 8;
  localparam int GAIN_W   = 9;

  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int FIFO_DEPTH_DEF     = 3;

  localparam int GAIN_RESET  = 179;
  localparam int QDIV        = 255;
  localparam int QMAX        = 127;
  localparam int QSAT_LIM    = QMAX * QDIV;
  // floor(m / 255) == ((m + 1) * 257) >> 16 for m below QSAT_LIM
  localparam int RECIP_MUL   = 257;
  localparam int RECIP_SHIFT = 16;
  localparam int GAIN_SHIFT  = 8;

  localparam longint E8 = 64'sd100000000;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_GAIN = 1'b0,
    REG_BWD_GAIN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CMD_W-1:0] surge_cmd;
    logic signed [CMD_W-1:0] sway_cmd;
    logic signed [CMD_W-1:0] heave_cmd;
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;
  } cmd_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_0;
    logic signed [SPEED_W-1:0] speed_1;
    logic signed [SPEED_W-1:0] speed_2;
    logic signed [SPEED_W-1:0] speed_3;
    logic signed [SPEED_W-1:0] speed_4;
    logic signed [SPEED_W-1:0] speed_5;
    logic signed [SPEED_W-1:0] speed_6;
    logic signed [SPEED_W-1:0] speed_7;
  } speed_t;

  // Mixing rows in units of 1e-8; last column is the row scale.
  localparam longint MIX_E8 [N_THR][N_CMD+1] = '{
    '{-40411490, -25000000, -35350677,  100000000,  30000000,  100000000, -100000000},
    '{-40411490,  25000000, -35350670, -100000000,  30000000, -100000000,  150000000},
    '{-40411490,  25000000,  35350670, -100000000,  30000000,  100000000,  100000000},
    '{ 40411490,  25000000, -35350677,  100000000, -30000000,  100000000,  150000000},
    '{-40411496, -25000000,  35350677,  100000000, -30000000,  100000000,  150000000},
    '{-40411496,  25000000,  35350670, -100000000, -30000000, -100000000, -150000000},
    '{ 40411490,  25000000,  35350677,  100000000,  30000000,  100000000,  100000000},
    '{ 40411496, -25000000,  35350670, -100000000,  30000000, -100000000,  150000000}
  };

  // Round half away from zero into fixed point with frac fraction bits.
  function automatic longint to_fixed(input longint c, input int frac);
    longint one;
    longint mag;
    longint r;
    one = 64'sd1 <<< frac;
    mag = (c < 0) ? -c : c;
    r   = (mag * one + E8 / 2) / E8;
    return (c < 0) ? -r : r;
  endfunction

endpackage

// File: design/tmm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_fifo: small request queue
// Register-based FIFO with occupancy count; used on both sides of the engine.
// ----------------------------------------------------------------------------
module tmm_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  T                             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output T                             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/tmm_row_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmm_row_engine: per-thruster mixing pipeline
// Issues one thruster row per cycle into an eight-stage datapath (a request
// waits for output credit) and assembles eight drive values into one result.
// ----------------------------------------------------------------------------
module tmm_row_engine #(
  parameter int COEF_FRAC_BITS = tmm_pkg::COEF_FRAC_BITS_DEF,
  parameter int OUT_DEPTH      = tmm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tmm_pkg::cmd_t                      cmd_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_pop_o,
  input  logic [tmm_pkg::GAIN_W-1:0]         fwd_gain_i,
  input  logic [tmm_pkg::GAIN_W-1:0]         bwd_gain_i,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count_i,
  output tmm_pkg::speed_t                    res_o,
  output logic                               res_push_o
);
  import tmm_pkg::*;

  localparam int COEF_W  = COEF_FRAC_BITS + 2;
  localparam int PROD_W  = CMD_W + COEF_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int DOT_W   = ACC_W - COEF_FRAC_BITS;
  localparam int SP_W    = DOT_W + COEF_W;
  localparam int SC_W    = SP_W - COEF_FRAC_BITS;
  localparam int MAG_W   = $clog2(QSAT_LIM);
  localparam int RP_W    = MAG_W + $clog2(RECIP_MUL) + 1;
  localparam int QMAG_W  = $clog2(QMAX + 1);
  localparam int GP_W    = QMAG_W + GAIN_W;
  localparam int GM_W    = GP_W - GAIN_SHIFT;
  localparam int ROW_W   = $clog2(N_THR);
  localparam int CNT_W   = $clog2(OUT_DEPTH+1);
  localparam int N_STG   = 7;

  logic signed [COEF_W-1:0] coef_tab [N_THR][N_CMD+1];

  for (genvar r = 0; r < N_THR; r++) begin : g_row
    for (genvar c = 0; c <= N_CMD; c++) begin : g_col
      assign coef_tab[r][c] = COEF_W'(to_fixed(MIX_E8[r][c], COEF_FRAC_BITS));
    end
  end

  // issue control
  logic [ROW_W-1:0] issue_row_q, issue_row_d;
  logic [CNT_W-1:0] inflight_q, inflight_d;
  logic             credit, issue, start;
  logic             push_q;

  assign credit = ({1'b0, inflight_q} + {1'b0, out_count_i}) < (CNT_W+1)'(OUT_DEPTH);
  assign issue  = (issue_row_q != '0) || (cmd_valid_i && credit);
  assign start  = issue && (issue_row_q == '0);
  assign cmd_pop_o = issue && (issue_row_q == ROW_W'(N_THR-1));

  always_comb begin
    issue_row_d = issue_row_q;
    inflight_d  = inflight_q;
    if (issue) begin
      issue_row_d = (issue_row_q == ROW_W'(N_THR-1)) ? '0 : issue_row_q + 1'b1;
    end
    if (start && !push_q) begin
      inflight_d = inflight_q + 1'b1;
    end else if (push_q && !start) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  // stage tags
  logic [N_STG-1:0] vld_q;
  logic [ROW_W-1:0] row_tag_q [N_STG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_row_q <= '0;
      inflight_q  <= '0;
      vld_q       <= '0;
      push_q      <= 1'b0;
    end else begin
      issue_row_q <= issue_row_d;
      inflight_q  <= inflight_d;
      vld_q       <= {vld_q[N_STG-2:0], issue};
      push_q      <= vld_q[N_STG-1] && (row_tag_q[N_STG-1] == ROW_W'(N_THR-1));
    end
  end

  always_ff @(posedge clk_i) begin
    row_tag_q[0] <= issue_row_q;
    for (int s = 1; s < N_STG; s++) begin
      row_tag_q[s] <= row_tag_q[s-1];
    end
  end

  // S1: six products
  logic signed [CMD_W-1:0]  cmd_arr [N_CMD];
  logic signed [PROD_W-1:0] prod_d  [N_CMD];
  logic signed [PROD_W-1:0] prod_q  [N_CMD];

  always_comb begin
    cmd_arr[0] = cmd_i.surge_cmd;
    cmd_arr[1] = cmd_i.sway_cmd;
    cmd_arr[2] = cmd_i.heave_cmd;
    cmd_arr[3] = cmd_i.roll_cmd;
    cmd_arr[4] = cmd_i.pitch_cmd;
    cmd_arr[5] = cmd_i.yaw_cmd;
    for (int k = 0; k < N_CMD; k++) begin
      prod_d[k] = PROD_W'(cmd_arr[k]) * PROD_W'(coef_tab[issue_row_q][k]);
    end
  end

  // S2: sum
  logic signed [ACC_W-1:0] acc_d, acc_q;

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < N_CMD; k++) begin
      acc_d = acc_d + ACC_W'(prod_q[k]);
    end
  end

  // S3: drop fraction toward zero
  logic signed [DOT_W-1:0] dot_d, dot_q;
  logic                    dot_rnd;

  assign dot_rnd = acc_q[ACC_W-1] && (acc_q[COEF_FRAC_BITS-1:0] != '0);
  assign dot_d   = DOT_W'(acc_q >>> COEF_FRAC_BITS) + DOT_W'(dot_rnd);

  // S4: row scale
  logic signed [SP_W-1:0] sprod_d, sprod_q;

  assign sprod_d = SP_W'(dot_q) * SP_W'(coef_tab[row_tag_q[2]][N_CMD]);

  // S5: drop fraction toward zero
  logic signed [SC_W-1:0] scaled_d, scaled_q;
  logic                   sc_rnd;

  assign sc_rnd   = sprod_q[SP_W-1] && (sprod_q[COEF_FRAC_BITS-1:0] != '0);
  assign scaled_d = SC_W'(sprod_q >>> COEF_FRAC_BITS) + SC_W'(sc_rnd);

  // S6: sign, magnitude, saturation
  logic [SC_W-1:0]  abs_d;
  logic             neg6_q, sat6_q;
  logic [MAG_W-1:0] mag6_q;

  assign abs_d = scaled_q[SC_W-1] ? SC_W'(-scaled_q) : SC_W'(scaled_q);

  // S7: divide by 255 and clamp
  logic [RP_W-1:0]   recip_prod;
  logic [QMAG_W-1:0] qmag_d, qmag7_q;
  logic              neg7_q;

  assign recip_prod = (RP_W'(mag6_q) + RP_W'(1)) * RP_W'(RECIP_MUL);
  assign qmag_d     = sat6_q ? QMAG_W'(QMAX) : QMAG_W'(recip_prod >> RECIP_SHIFT);

  // S8: gain, saturate, restore sign
  logic [GAIN_W-1:0]         gain_sel;
  logic [GP_W-1:0]           gain_prod;
  logic [GM_W-1:0]           gain_mag;
  logic [QMAG_W-1:0]         sp_mag;
  logic signed [SPEED_W-1:0] speed_d;
  logic signed [SPEED_W-1:0] speed_q [N_THR];

  always_comb begin
    gain_sel  = neg7_q ? bwd_gain_i : fwd_gain_i;
    gain_prod = GP_W'(qmag7_q) * GP_W'(gain_sel);
    gain_mag  = GM_W'(gain_prod >> GAIN_SHIFT);
    sp_mag    = (gain_mag > GM_W'(QMAX)) ? QMAG_W'(QMAX) : QMAG_W'(gain_mag);
    speed_d   = neg7_q ? -SPEED_W'(sp_mag) : SPEED_W'(sp_mag);
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    dot_q    <= dot_d;
    sprod_q  <= sprod_d;
    scaled_q <= scaled_d;
    neg6_q   <= scaled_q[SC_W-1];
    sat6_q   <= (abs_d >= SC_W'(QSAT_LIM));
    mag6_q   <= MAG_W'(abs_d);
    qmag7_q  <= qmag_d;
    neg7_q   <= neg6_q;
    if (vld_q[N_STG-1]) begin
      speed_q[row_tag_q[N_STG-1]] <= speed_d;
    end
  end

  assign res_push_o    = push_q;
  assign res_o.speed_0 = speed_q[0];
  assign res_o.speed_1 = speed_q[1];
  assign res_o.speed_2 = speed_q[2];
  assign res_o.speed_3 = speed_q[3];
  assign res_o.speed_4 = speed_q[4];
  assign res_o.speed_5 = speed_q[5];
  assign res_o.speed_6 = speed_q[6];
  assign res_o.speed_7 = speed_q[7];

endmodule

// File: design/thruster_mixing_matrix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thruster_mixing_matrix_core: six-axis to eight-thruster mixer
// Requests are pipelined: the row engine issues one thruster row per cycle
// through its shared multiplier pipeline and can start the next request while
// earlier rows are still in flight, when output-queue credit allows.
// Reset: queues empty, both gains return to 179.
// ----------------------------------------------------------------------------
module thruster_mixing_matrix_core #(
  parameter int COEF_FRAC_BITS = tmm_pkg::COEF_FRAC_BITS_DEF,
  parameter int FIFO_DEPTH     = tmm_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  tmm_pkg::cmd_t                  cmd_i,
  output logic                           full,
  input  logic                           pop,
  output tmm_pkg::speed_t                speed_o,
  output logic                           empty,
  input  logic                           cfg_we_i,
  input  logic [tmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tmm_pkg::GAIN_W-1:0]     cfg_wdata_i
);
  import tmm_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH+1);

  logic [GAIN_W-1:0] fwd_gain_q, bwd_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_gain_q <= GAIN_W'(GAIN_RESET);
      bwd_gain_q <= GAIN_W'(GAIN_RESET);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FWD_GAIN: fwd_gain_q <= cfg_wdata_i;
        REG_BWD_GAIN: bwd_gain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: request queue
  cmd_t             head_cmd;
  logic             in_empty, cmd_pop;
  logic [CNT_W-1:0] in_count;

  tmm_fifo #(
    .T     (cmd_t),
    .DEPTH (FIFO_DEPTH)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_i),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (head_cmd),
    .empty_o (in_empty),
    .count_o (in_count)
  );

  // back: row engine
  speed_t           res;
  logic             res_push, out_full;
  logic [CNT_W-1:0] out_count;

  tmm_row_engine #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .OUT_DEPTH      (FIFO_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!in_empty),
    .cmd_pop_o   (cmd_pop),
    .fwd_gain_i  (fwd_gain_q),
    .bwd_gain_i  (bwd_gain_q),
    .out_count_i (out_count),
    .res_o       (res),
    .res_push_o  (res_push)
  );

  tmm_fifo #(
    .T     (speed_t),
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (speed_o),
    .empty_o (empty),
    .count_o (out_count)
  );

  localparam logic signed [SPEED_W-1:0] SPEED_NEG_FULL = {1'b1, {(SPEED_W-1){1'b0}}};

  a_no_out_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !out_full)
    else $error("result pushed into full output queue");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !in_empty)
    else $error("engine popped an empty request queue");

  a_no_count_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_count) == CNT_W'(FIFO_DEPTH) && !$past(cmd_pop)) |-> full)
    else $error("request queue count changed without a pop");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (speed_o.speed_0 != SPEED_NEG_FULL) && (speed_o.speed_1 != SPEED_NEG_FULL)
            && (speed_o.speed_2 != SPEED_NEG_FULL) && (speed_o.speed_3 != SPEED_NEG_FULL)
            && (speed_o.speed_4 != SPEED_NEG_FULL) && (speed_o.speed_5 != SPEED_NEG_FULL)
            && (speed_o.speed_6 != SPEED_NEG_FULL) && (speed_o.speed_7 != SPEED_NEG_FULL))
    else $error("drive value outside +-127");

endmodule
